// ===== design/yfade_pkg.sv =====
// ----------------------------------------------------------------------------
// yfade_pkg
// shared types, coefficients and clipping helper for the ycbcr fade pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package yfade_pkg;

  localparam int unsigned SumW = 20;

  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // ycbcr to rgb
  localparam sum_t K_Y    = 20'sd298;
  localparam sum_t K_RV   = 20'sd409;
  localparam sum_t K_GU   = 20'sd100;
  localparam sum_t K_GV   = 20'sd208;
  localparam sum_t K_BU   = 20'sd516;
  // rgb to ycbcr
  localparam sum_t K_YR   = 20'sd66;
  localparam sum_t K_YG   = 20'sd129;
  localparam sum_t K_YB   = 20'sd25;
  localparam sum_t K_UR   = 20'sd38;
  localparam sum_t K_UG   = 20'sd74;
  localparam sum_t K_UB   = 20'sd112;
  localparam sum_t K_VR   = 20'sd112;
  localparam sum_t K_VG   = 20'sd94;
  localparam sum_t K_VB   = 20'sd18;
  localparam sum_t RND    = 20'sd128;
  localparam sum_t OFS_Y  = 20'sd16;
  localparam sum_t OFS_C  = 20'sd128;
  localparam sum_t ZERO   = 20'sd0;

  localparam logic [7:0] GAIN_RST = 8'd255;

  // floor shift by 8, add offset, saturate to a byte
  function automatic logic [7:0] clip_asr8(input sum_t x, input sum_t ofs);
    sum_t s;
    s = (x >>> 8) + ofs;
    if (s < 0) begin
      clip_asr8 = 8'd0;
    end else if (s > 20'sd255) begin
      clip_asr8 = 8'd255;
    end else begin
      clip_asr8 = s[7:0];
    end
  endfunction

  function automatic sum_t ext8(input logic [7:0] v);
    ext8 = signed'({12'd0, v});
  endfunction

endpackage

`default_nettype wire

// ===== design/yuv_fade_yuv_pixel.sv =====
// ----------------------------------------------------------------------------
// yuv_fade_yuv_pixel
// fades one 8-bit ycbcr pixel per clock (unless the output stalls) through rgb with bt.601 integer math
//
// input channel: in_valid_i / in_ready_o with luma_in_i, cb_in_i, cr_in_i
// output channel: out_valid_o / out_ready_i with luma_out_o, cb_out_o,
//   cr_out_o; one output word per input word, in order
// config channel: cfg_valid_i / cfg_ready_o with cfg_data_i as the fade
//   gain (over 255); always ready, write only while the pipe is empty
// pipeline registers: rgb sums, gain multiply, divide by 255, back
//   conversion into the output register
// throughput: one word per cycle while out_ready_i does not stall, set by the four-stage pipeline
// stall: when out_ready_i is low with a word waiting, the whole pipe
//   holds and in_ready_o drops; nothing is lost or repeated
// reset: all valid bits clear and the gain returns to 255
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_fade_yuv_pixel (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] luma_in_i,
  input  wire logic [7:0] cb_in_i,
  input  wire logic [7:0] cr_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      luma_out_o,
  output logic [7:0]      cb_out_o,
  output logic [7:0]      cr_out_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);
  import yfade_pkg::*;

  logic       en;
  logic [3:0] vld_q;
  logic [3:0] vld_d;
  logic [7:0] gain_q;
  rgb_t       rgb_s1;
  rgb_t       rgb_s3;

  assign en          = !vld_q[3] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[3];
  assign cfg_ready_o = 1'b1;
  assign vld_d       = {vld_q[2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      gain_q <= GAIN_RST;
    end else begin
      if (en) begin
        vld_q <= vld_d;
      end
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
    end
  end

  yfade_to_rgb u_to_rgb (
    .clk_i  (clk_i),
    .en_i   (en),
    .luma_i (luma_in_i),
    .cb_i   (cb_in_i),
    .cr_i   (cr_in_i),
    .rgb_o  (rgb_s1)
  );

  yfade_scale u_scale (
    .clk_i  (clk_i),
    .en_i   (en),
    .rgb_i  (rgb_s1),
    .gain_i (gain_q),
    .rgb_o  (rgb_s3)
  );

  yfade_to_ycc u_to_ycc (
    .clk_i  (clk_i),
    .en_i   (en),
    .rgb_i  (rgb_s3),
    .luma_o (luma_out_o),
    .cb_o   (cb_out_o),
    .cr_o   (cr_out_o)
  );

endmodule

`default_nettype wire

// ===== design/yfade_to_rgb.sv =====
// ----------------------------------------------------------------------------
// yfade_to_rgb
// first stage: bt.601 ycbcr to rgb sums, registered, then clipped to bytes
// ----------------------------------------------------------------------------
`default_nettype none

module yfade_to_rgb (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [7:0]    luma_i,
  input  wire logic [7:0]    cb_i,
  input  wire logic [7:0]    cr_i,
  output yfade_pkg::rgb_t    rgb_o
);
  import yfade_pkg::*;

  sum_t c, d, e;
  sum_t sum_r_d, sum_g_d, sum_b_d;
  sum_t sum_r_q, sum_g_q, sum_b_q;

  always_comb begin
    c = ext8(luma_i) - OFS_Y;
    d = ext8(cb_i) - OFS_C;
    e = ext8(cr_i) - OFS_C;
    sum_r_d = K_Y * c + K_RV * e + RND;
    sum_g_d = K_Y * c - K_GU * d - K_GV * e + RND;
    sum_b_d = K_Y * c + K_BU * d + RND;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
    end
  end

  always_comb begin
    rgb_o.r = clip_asr8(sum_r_q, ZERO);
    rgb_o.g = clip_asr8(sum_g_q, ZERO);
    rgb_o.b = clip_asr8(sum_b_q, ZERO);
  end

endmodule

`default_nettype wire

// ===== design/yfade_scale.sv =====
// ----------------------------------------------------------------------------
// yfade_scale
// gain multiply then exact divide by 255, one register stage each
// ----------------------------------------------------------------------------
`default_nettype none

module yfade_scale (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire yfade_pkg::rgb_t rgb_i,
  input  wire logic [7:0]    gain_i,
  output yfade_pkg::rgb_t    rgb_o
);
  import yfade_pkg::*;

  logic [15:0] prod_d [3];
  logic [15:0] prod_q [3];
  logic [7:0]  quot_d [3];
  logic [16:0] acc    [3];
  rgb_t        rgb_q;

  always_comb begin
    prod_d[0] = {8'd0, rgb_i.r} * {8'd0, gain_i};
    prod_d[1] = {8'd0, rgb_i.g} * {8'd0, gain_i};
    prod_d[2] = {8'd0, rgb_i.b} * {8'd0, gain_i};
    // floor(p / 255) for p up to 255 * 255, the largest product
    for (int i = 0; i < 3; i++) begin
      acc[i]    = {1'b0, prod_q[i]} + 17'd1 + {9'd0, prod_q[i][15:8]};
      quot_d[i] = acc[i][15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      rgb_q.r <= quot_d[0];
      rgb_q.g <= quot_d[1];
      rgb_q.b <= quot_d[2];
    end
  end

  assign rgb_o = rgb_q;

endmodule

`default_nettype wire

// ===== design/yfade_to_ycc.sv =====
// ----------------------------------------------------------------------------
// yfade_to_ycc
// last stage: rgb back to bt.601 ycbcr, clipped, into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module yfade_to_ycc (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire yfade_pkg::rgb_t rgb_i,
  output logic [7:0]         luma_o,
  output logic [7:0]         cb_o,
  output logic [7:0]         cr_o
);
  import yfade_pkg::*;

  sum_t r, g, b;
  sum_t sum_y, sum_u, sum_v;
  logic [7:0] luma_d, cb_d, cr_d;
  logic [7:0] luma_q, cb_q, cr_q;

  always_comb begin
    r = ext8(rgb_i.r);
    g = ext8(rgb_i.g);
    b = ext8(rgb_i.b);
    sum_y  = K_YR * r + K_YG * g + K_YB * b + RND;
    sum_u  = K_UB * b - K_UR * r - K_UG * g + RND;
    sum_v  = K_VR * r - K_VG * g - K_VB * b + RND;
    luma_d = clip_asr8(sum_y, OFS_Y);
    cb_d   = clip_asr8(sum_u, OFS_C);
    cr_d   = clip_asr8(sum_v, OFS_C);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      luma_q <= luma_d;
      cb_q   <= cb_d;
      cr_q   <= cr_d;
    end
  end

  assign luma_o = luma_q;
  assign cb_o   = cb_q;
  assign cr_o   = cr_q;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// bench for yuv_fade_yuv_pixel: drives pixel words with random gaps and
// output stalls, predicts each faded pixel through rgb in integer bt.601
// math, and compares every output word field by field, in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int PipeDelay = 4;
  localparam int StallLimit = 4000;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } pixel_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] luma_in_i = 8'd0;
  logic [7:0] cb_in_i = 8'd0;
  logic [7:0] cr_in_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] luma_out_o;
  logic [7:0] cb_out_o;
  logic [7:0] cr_out_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'd0;

  logic [7:0] fade_gain_r = yfade_pkg::GAIN_RST;
  pixel_t     faded_q[$];
  int         in_idle_pct = 9;
  int         out_idle_pct = 47;
  int         mismatch_cnt = 0;
  int         quiet_cycles = 0;

  yuv_fade_yuv_pixel u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .luma_in_i   (luma_in_i),
    .cb_in_i     (cb_in_i),
    .cr_in_i     (cr_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .luma_out_o  (luma_out_o),
    .cb_out_o    (cb_out_o),
    .cr_out_o    (cr_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int sat_byte(input int x);
    if (x < 0) begin
      return 0;
    end else if (x > 255) begin
      return 255;
    end
    return x;
  endfunction

  function automatic pixel_t fade_pixel(input logic [7:0] y, input logic [7:0] u,
                                        input logic [7:0] v, input logic [7:0] gain);
    int c, d, e, gn;
    int rc, gc, bc, r, g, b;
    pixel_t px;
    c  = int'(y) - 16;
    d  = int'(u) - 128;
    e  = int'(v) - 128;
    gn = int'(gain);
    rc = sat_byte((298 * c + 409 * e + 128) >>> 8);
    gc = sat_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
    bc = sat_byte((298 * c + 516 * d + 128) >>> 8);
    r  = rc * gn / 255;
    g  = gc * gn / 255;
    b  = bc * gn / 255;
    px.luma = 8'(sat_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16));
    px.cb   = 8'(sat_byte(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128));
    px.cr   = 8'(sat_byte(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128));
    return px;
  endfunction

  // sink side: random stalls and in-order compare
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (faded_q.size() == 0) begin
        $error("output word with nothing expected: %0d %0d %0d",
               luma_out_o, cb_out_o, cr_out_o);
        mismatch_cnt++;
      end else begin
        want = faded_q.pop_front();
        if (luma_out_o !== want.luma) begin
          $error("luma_out expected %0d actual %0d", want.luma, luma_out_o);
          mismatch_cnt++;
        end
        if (cb_out_o !== want.cb) begin
          $error("cb_out expected %0d actual %0d", want.cb, cb_out_o);
          mismatch_cnt++;
        end
        if (cr_out_o !== want.cr) begin
          $error("cr_out expected %0d actual %0d", want.cr, cr_out_o);
          mismatch_cnt++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [7:0] y, input logic [7:0] u, input logic [7:0] v);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    luma_in_i  <= y;
    cb_in_i    <= u;
    cr_in_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    faded_q.push_back(fade_pixel(y, u, v, fade_gain_r));
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (faded_q.size() != 0) @(posedge clk_i);
    repeat (PipeDelay + 2) @(posedge clk_i);
  endtask

  task automatic set_gain(input logic [7:0] gain);
    drain_pipe();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= gain;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    fade_gain_r = gain;
    cfg_valid_i <= 1'b0;
  endtask

  // unity gain after reset, corners and out-of-gamut triples
  task automatic test_reset_gain();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd16, 8'd128, 8'd128);
    send_pixel(8'd235, 8'd128, 8'd128);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd0);
    send_pixel(8'd81, 8'd90, 8'd240);
    send_pixel(8'd145, 8'd54, 8'd34);
    send_pixel(8'd170, 8'd166, 8'd16);
    send_pixel(8'haa, 8'h55, 8'haa);
  endtask

  // black, smallest, near-unity and half gain
  task automatic test_gain_extremes();
    set_gain(8'd0);
    send_pixel(8'd255, 8'd128, 8'd128);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd200, 8'd40, 8'd220);
    set_gain(8'd1);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd235, 8'd128, 8'd128);
    set_gain(8'd254);
    send_pixel(8'd255, 8'd128, 8'd128);
    send_pixel(8'd55, 8'd200, 8'd60);
    set_gain(8'd128);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'h55, 8'haa, 8'h55);
  endtask

  task automatic test_random(input int chunks, input int per_chunk);
    logic [7:0] y, u, v;
    for (int k = 0; k < chunks; k++) begin
      case (k)
        0:       set_gain(8'd255);
        1:       set_gain(8'd0);
        default: set_gain(8'($urandom_range(255)));
      endcase
      for (int n = 0; n < per_chunk; n++) begin
        if ($urandom_range(9) < 7) begin
          y = 8'($urandom_range(255));
          u = 8'($urandom_range(255));
          v = 8'($urandom_range(255));
        end else begin
          // studio-range pixel
          y = 8'($urandom_range(235, 16));
          u = 8'($urandom_range(240, 16));
          v = 8'($urandom_range(240, 16));
        end
        send_pixel(y, u, v);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct  = 9;
    out_idle_pct = 47;
    test_reset_gain();
    test_gain_extremes();
    test_random(5, 77);

    in_idle_pct  = 47;
    out_idle_pct = 9;
    test_random(5, 77);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random(5, 77);

    drain_pipe();
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
